@@ src/pwe_pkg.sv @@
// Shared types and constants for the particle weight estimator.
// Used by every module of the block; depends on nothing.
package pwe_pkg;

  localparam int CoordW = 16;
  localparam int DiffW = 17;
  localparam int SqW = 34;
  localparam int DistW = 17;
  localparam int EstW = 12;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdMeas = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic signed [EstW-1:0] est_t;

  // Request to the iterative square-root unit.
  typedef struct packed {
    logic start;
    logic [SqW-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic done;
    dist_t root;
  } sqrt_rsp_t;

endpackage

@@ src/pwe_store.sv @@
// Particle position and distance memories with registered read data.
// Depends on pwe_pkg.
module pwe_store #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic clk,
  input  logic pos_we,
  input  logic [AddrW-1:0] pos_waddr,
  input  pwe_pkg::coord_t pos_wx,
  input  pwe_pkg::coord_t pos_wy,
  input  logic dist_we,
  input  logic [AddrW-1:0] dist_waddr,
  input  pwe_pkg::dist_t dist_wdata,
  input  logic [AddrW-1:0] raddr,
  output pwe_pkg::coord_t rx,
  output pwe_pkg::coord_t ry,
  output pwe_pkg::dist_t rdist
);

  logic [2*pwe_pkg::CoordW-1:0] pos_mem [Depth];
  pwe_pkg::dist_t dist_mem [Depth];
  logic [2*pwe_pkg::CoordW-1:0] pos_q;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= {pos_wx, pos_wy};
    end
    pos_q <= pos_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    rdist <= dist_mem[raddr];
  end

  assign rx = pwe_pkg::coord_t'(pos_q[2*pwe_pkg::CoordW-1:pwe_pkg::CoordW]);
  assign ry = pwe_pkg::coord_t'(pos_q[pwe_pkg::CoordW-1:0]);

endmodule

@@ src/pwe_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on pwe_pkg.
module pwe_sqrt (
  input  logic clk,
  input  logic rst,
  input  pwe_pkg::sqrt_req_t req,
  output pwe_pkg::sqrt_rsp_t rsp
);

  localparam int SqW = pwe_pkg::SqW;
  localparam int RootW = pwe_pkg::DistW;

  logic [SqW-1:0] rem;
  logic [SqW-1:0] val;
  logic [RootW-1:0] root;
  logic [4:0] step;
  logic busy;
  logic done;
  logic [SqW+1:0] trial_rem;
  logic [SqW+1:0] trial_sub;

  always_comb begin
    trial_rem = {rem, val[SqW-1:SqW-2]};
    trial_sub = {{(SqW+2-RootW-2){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= '0;
        val <= req.radicand;
        root <= '0;
        step <= 5'(RootW - 1);
      end else if (busy) begin
        val <= {val[SqW-3:0], 2'b00};
        if (trial_rem >= trial_sub) begin
          rem <= SqW'(trial_rem - trial_sub);
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem <= SqW'(trial_rem);
          root <= {root[RootW-2:0], 1'b0};
        end
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 5'd1;
        end
      end
    end
  end

  assign rsp = {done, root};

endmodule

@@ src/pwe_div.sv @@
// Iterative restoring divider with half-away rounding and 12-bit clamp.
// Depends on pwe_pkg.
module pwe_div #(
  parameter int NumW = 42,
  parameter int DenW = 34
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic done,
  output pwe_pkg::est_t est
);

  // Quotient = (2*|num| + 16*den) / (32*den).
  localparam int DW = DenW + 5;
  localparam int MW = NumW + DenW + 6;
  localparam int CntW = $clog2(MW + 1);

  logic neg;
  logic busy;
  logic [MW-1:0] dividend;
  logic [DW-1:0] divisor;
  logic [DW:0] rem;
  logic [MW-1:0] quo;
  logic [CntW-1:0] cnt;
  logic [DW:0] shifted;
  logic [NumW-1:0] mag;

  always_comb begin
    mag = num[NumW-1] ? NumW'(-num) : NumW'(num);
    shifted = {rem[DW-1:0], dividend[MW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg <= num[NumW-1];
        dividend <= MW'({mag, 1'b0}) + MW'({den, 4'b0});
        divisor <= {den, 5'b0};
        rem <= '0;
        quo <= '0;
        cnt <= CntW'(MW - 1);
      end else if (busy) begin
        dividend <= {dividend[MW-2:0], 1'b0};
        if (shifted >= {1'b0, divisor}) begin
          rem <= shifted - {1'b0, divisor};
          quo <= {quo[MW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[MW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CntW'(1);
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      est = (quo > MW'(2048)) ? -12'sd2048 : pwe_pkg::est_t'(-quo[11:0]);
    end else begin
      est = (quo > MW'(2047)) ? 12'sd2047 : pwe_pkg::est_t'(quo[11:0]);
    end
  end

endmodule

@@ src/particle_weight_estimator.sv @@
// Top level of the particle weight estimator: control sequencer and accumulators.
// Depends on pwe_pkg, pwe_store, pwe_sqrt and pwe_div.
//
// Loads stream at one per cycle while the block is idle and no result waits on the
// output. A measurement walks the store twice: the first pass computes each
// particle's distance in the bit-serial square-root unit, the second pass reads
// each particle again through the memory read port to accumulate weighted
// positions, and the final two divisions run in the bit-serial divider. An empty
// set answers in the cycle after its measurement transfer. The memories need no
// clearing pass.
module particle_weight_estimator #(
  parameter int MAX_PARTICLES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic cmd,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [11:0] est_x,
  output logic signed [11:0] est_y,
  output logic empty_res
);

  localparam int AddrW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CntW = $clog2(MAX_PARTICLES + 1);
  localparam int SwW = pwe_pkg::DistW + 1 + CntW;
  localparam int SxW = pwe_pkg::CoordW + pwe_pkg::DistW + 1 + CntW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1 = 4'd1;
  localparam logic [3:0] S_SQ = 4'd2;
  localparam logic [3:0] S_SQW = 4'd3;
  localparam logic [3:0] S_RD2 = 4'd4;
  localparam logic [3:0] S_ACC = 4'd5;
  localparam logic [3:0] S_DIVX = 4'd6;
  localparam logic [3:0] S_DIVXW = 4'd7;
  localparam logic [3:0] S_DIVY = 4'd8;
  localparam logic [3:0] S_DIVYW = 4'd9;

  logic [3:0] state;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  pwe_pkg::coord_t meas_x;
  pwe_pkg::coord_t meas_y;
  pwe_pkg::dist_t max_dist;
  logic signed [SxW-1:0] sx;
  logic signed [SxW-1:0] sy;
  logic [SwW-1:0] sw;
  pwe_pkg::est_t res_x;

  logic in_xfer;
  logic out_xfer;
  pwe_pkg::coord_t rx;
  pwe_pkg::coord_t ry;
  pwe_pkg::dist_t rdist;
  logic dist_we;
  pwe_pkg::sqrt_req_t sq_req;
  pwe_pkg::sqrt_rsp_t sq_rsp;
  logic signed [pwe_pkg::DiffW-1:0] dx;
  logic signed [pwe_pkg::DiffW-1:0] dy;
  logic [pwe_pkg::DistW:0] weight;
  logic signed [pwe_pkg::DistW+1:0] weight_s;
  logic signed [pwe_pkg::CoordW+pwe_pkg::DistW+1:0] px_w;
  logic signed [pwe_pkg::CoordW+pwe_pkg::DistW+1:0] py_w;
  logic div_start;
  logic div_done;
  logic signed [SxW-1:0] div_num;
  pwe_pkg::est_t div_est;
  logic pos_we;

  assign in_xfer = valid && ready;
  assign out_xfer = out_valid && out_ready;
  assign ready = (state == S_IDLE) && !out_valid;
  assign pos_we = in_xfer && (cmd == pwe_pkg::CmdLoad) && (count < CntW'(MAX_PARTICLES));

  pwe_store #(.Depth(MAX_PARTICLES), .AddrW(AddrW)) u_store (
    .clk(clk),
    .pos_we(pos_we),
    .pos_waddr(count[AddrW-1:0]),
    .pos_wx(coord_x),
    .pos_wy(coord_y),
    .dist_we(dist_we),
    .dist_waddr(idx[AddrW-1:0]),
    .dist_wdata(sq_rsp.root),
    .raddr(idx[AddrW-1:0]),
    .rx(rx),
    .ry(ry),
    .rdist(rdist)
  );

  always_comb begin
    dx = pwe_pkg::DiffW'(rx) - pwe_pkg::DiffW'(meas_x);
    dy = pwe_pkg::DiffW'(ry) - pwe_pkg::DiffW'(meas_y);
  end

  // Squares are registered inside the request, then iterated.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_req.start <= 1'b0;
    end else begin
      sq_req.start <= (state == S_SQ);
    end
    sq_req.radicand <= pwe_pkg::SqW'(dx * dx) + pwe_pkg::SqW'(dy * dy);
  end

  pwe_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .rsp(sq_rsp));

  assign dist_we = (state == S_SQW) && sq_rsp.done;
  assign weight = {1'b0, max_dist} - {1'b0, rdist} + 18'd1;
  assign weight_s = $signed({1'b0, weight});
  assign px_w = rx * weight_s;
  assign py_w = ry * weight_s;

  assign div_start = (state == S_DIVX) || (state == S_DIVY);
  assign div_num = (state == S_DIVX) ? sx : sy;

  pwe_div #(.NumW(SxW), .DenW(SwW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(sw),
    .done(div_done), .est(div_est)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx <= '0;
      max_dist <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (cmd == pwe_pkg::CmdLoad) begin
              if (pos_we) begin
                count <= count + CntW'(1);
              end
            end else if (count == '0) begin
              est_x <= '0;
              est_y <= '0;
              empty_res <= 1'b1;
              out_valid <= 1'b1;
            end else begin
              meas_x <= coord_x;
              meas_y <= coord_y;
              idx <= '0;
              max_dist <= '0;
              state <= S_RD1;
            end
          end
        end
        S_RD1: state <= S_SQ;
        S_SQ: state <= S_SQW;
        S_SQW: begin
          if (sq_rsp.done) begin
            if (sq_rsp.root > max_dist) begin
              max_dist <= sq_rsp.root;
            end
            if (idx == count - CntW'(1)) begin
              idx <= '0;
              sx <= '0;
              sy <= '0;
              sw <= '0;
              state <= S_RD2;
            end else begin
              idx <= idx + CntW'(1);
              state <= S_RD1;
            end
          end
        end
        S_RD2: state <= S_ACC;
        S_ACC: begin
          sx <= sx + SxW'(px_w);
          sy <= sy + SxW'(py_w);
          sw <= sw + SwW'(weight);
          if (idx == count - CntW'(1)) begin
            state <= S_DIVX;
          end else begin
            idx <= idx + CntW'(1);
            state <= S_RD2;
          end
        end
        S_DIVX: state <= S_DIVXW;
        S_DIVXW: begin
          if (div_done) begin
            res_x <= div_est;
            state <= S_DIVY;
          end
        end
        S_DIVY: state <= S_DIVYW;
        S_DIVYW: begin
          if (div_done) begin
            est_x <= res_x;
            est_y <= div_est;
            empty_res <= 1'b0;
            out_valid <= 1'b1;
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MAX_PARTICLES))
    else $error("particle count beyond capacity");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !ready)
    else $error("input ready while a measurement is in progress");

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVYW && div_done) |=> (count == '0 && out_valid))
    else $error("count not cleared on result");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (idx < count))
    else $error("store index beyond loaded particles");

endmodule

@@ dv/tb.sv @@
// Testbench for particle_weight_estimator: directed and random particle sets.
// Predicts each weighted-mean estimate in-line and checks every result transfer.
// Depends on pwe_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

  localparam int Cap = 256;
  localparam int IdleLimit = 40000;

  typedef struct {
    pwe_pkg::est_t ex;
    pwe_pkg::est_t ey;
    logic empty;
  } estimate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic cmd = pwe_pkg::CmdLoad;
  pwe_pkg::coord_t coord_x = '0;
  pwe_pkg::coord_t coord_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pwe_pkg::est_t est_x;
  pwe_pkg::est_t est_y;
  logic empty_res;

  estimate_t estimate_q[$];
  pwe_pkg::coord_t part_x[Cap];
  pwe_pkg::coord_t part_y[Cap];
  int part_n = 0;
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int ready_mode = 0;
  int ready_phase = 0;

  particle_weight_estimator u_top (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .cmd(cmd),
    .coord_x(coord_x), .coord_y(coord_y), .out_valid(out_valid),
    .out_ready(out_ready), .est_x(est_x), .est_y(est_y), .empty_res(empty_res)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic pwe_pkg::est_t round_pixels(longint num, longint unsigned wsum);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    den = wsum * 16;
    q = (2 * mag + den) / (2 * den);
    if (num < 0) begin
      return (q > 2048) ? pwe_pkg::est_t'(-2048) : pwe_pkg::est_t'(-longint'(q));
    end
    return (q > 2047) ? pwe_pkg::est_t'(2047) : pwe_pkg::est_t'(q);
  endfunction

  function automatic estimate_t estimate_for(pwe_pkg::coord_t mx, pwe_pkg::coord_t my);
    estimate_t e;
    longint unsigned dists[Cap];
    longint unsigned dmax;
    longint unsigned w;
    longint unsigned wsum;
    longint sx;
    longint sy;
    longint dx;
    longint dy;
    e.ex = '0;
    e.ey = '0;
    e.empty = 1'b1;
    if (part_n == 0) return e;
    dmax = 0;
    for (int i = 0; i < part_n; i++) begin
      dx = longint'(part_x[i]) - longint'(mx);
      dy = longint'(part_y[i]) - longint'(my);
      dists[i] = int_sqrt(dx * dx + dy * dy) & 17'h1ffff;
      if (dists[i] > dmax) dmax = dists[i];
    end
    sx = 0;
    sy = 0;
    wsum = 0;
    for (int i = 0; i < part_n; i++) begin
      w = dmax - dists[i] + 1;
      sx += longint'(part_x[i]) * longint'(w);
      sy += longint'(part_y[i]) * longint'(w);
      wsum += w;
    end
    e.ex = round_pixels(sx, wsum);
    e.ey = round_pixels(sy, wsum);
    e.empty = 1'b0;
    return e;
  endfunction

  task automatic report(string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_item(logic c, pwe_pkg::coord_t x, pwe_pkg::coord_t y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    valid <= 1'b1;
    cmd <= c;
    coord_x <= x;
    coord_y <= y;
    @(posedge clk);
    while (!ready) @(posedge clk);
    items_sent++;
    if (c == pwe_pkg::CmdLoad) begin
      if (part_n < Cap) begin
        part_x[part_n] = x;
        part_y[part_n] = y;
        part_n++;
      end
    end else begin
      estimate_q = {estimate_q, estimate_for(x, y)};
      part_n = 0;
    end
  endtask

  task automatic send_set(int n, int style);
    pwe_pkg::coord_t cx;
    pwe_pkg::coord_t cy;
    int spread;
    cx = pwe_pkg::coord_t'($urandom);
    cy = pwe_pkg::coord_t'($urandom);
    spread = $urandom_range(1, 4000);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: send_item(pwe_pkg::CmdLoad, pwe_pkg::coord_t'($urandom),
                     pwe_pkg::coord_t'($urandom));
        1: send_item(pwe_pkg::CmdLoad,
                     pwe_pkg::coord_t'(int'(cx) / 2 + $urandom_range(0, spread)),
                     pwe_pkg::coord_t'(int'(cy) / 2 + $urandom_range(0, spread)));
        default: send_item(pwe_pkg::CmdLoad, $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000,
                           $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      endcase
    end
    if (style == 1 && $urandom_range(0, 1))
      send_item(pwe_pkg::CmdMeas, pwe_pkg::coord_t'(int'(cx) / 2 + spread / 2),
                pwe_pkg::coord_t'(int'(cy) / 2 + spread / 2));
    else
      send_item(pwe_pkg::CmdMeas, pwe_pkg::coord_t'($urandom),
                pwe_pkg::coord_t'($urandom));
  endtask

  task automatic test_directed();
    send_item(pwe_pkg::CmdMeas, 16'sh7fff, 16'sh8000);
    send_item(pwe_pkg::CmdLoad, 16'sh8000, 16'sh8000);
    send_item(pwe_pkg::CmdMeas, 16'sh7fff, 16'sh7fff);
    send_item(pwe_pkg::CmdLoad, 16'sh7fff, 16'sh7fff);
    send_item(pwe_pkg::CmdMeas, 16'sh8000, 16'sh8000);
    send_item(pwe_pkg::CmdLoad, 16'sh0008, -16'sh0008);
    send_item(pwe_pkg::CmdMeas, 16'sh0000, 16'sh0000);
    send_item(pwe_pkg::CmdLoad, 16'sh7fff, 16'sh8000);
    send_item(pwe_pkg::CmdLoad, 16'sh8000, 16'sh7fff);
    send_item(pwe_pkg::CmdLoad, 16'sh0018, -16'sh0018);
    send_item(pwe_pkg::CmdMeas, 16'sh0000, 16'sh0000);
    send_item(pwe_pkg::CmdLoad, 16'sh1234, 16'sh0fff);
    send_item(pwe_pkg::CmdLoad, 16'sh1234, 16'sh0fff);
    send_item(pwe_pkg::CmdMeas, 16'sh1234, 16'sh0fff);
    send_item(pwe_pkg::CmdMeas, 16'sh0000, 16'sh0000);
  endtask

  task automatic test_store_full();
    for (int i = 0; i < Cap + 4; i++)
      send_item(pwe_pkg::CmdLoad, pwe_pkg::coord_t'($urandom),
                pwe_pkg::coord_t'($urandom));
    send_item(pwe_pkg::CmdMeas, pwe_pkg::coord_t'($urandom), pwe_pkg::coord_t'($urandom));
    send_set(Cap, 2);
  endtask

  task automatic test_random();
    int pick;
    while (items_sent < 1350) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) send_item(pwe_pkg::CmdMeas, pwe_pkg::coord_t'($urandom),
                              pwe_pkg::coord_t'($urandom));
      else if (pick < 16) send_set($urandom_range(13, 40), $urandom_range(0, 2));
      else send_set($urandom_range(1, 12), $urandom_range(0, 2));
    end
    valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (ready_phase == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_phase <= $urandom_range(20, 200);
    end else begin
      ready_phase <= ready_phase - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    estimate_t e;
    if (!rst && out_valid && out_ready) begin
      if (estimate_q.size() == 0) begin
        report("result transfer with no estimate pending");
      end else begin
        e = estimate_q.pop_front();
        if (est_x !== e.ex) report($sformatf("est_x %0d, want %0d", est_x, e.ex));
        if (est_y !== e.ey) report($sformatf("est_y %0d, want %0d", est_y, e.ey));
        if (empty_res !== e.empty)
          report($sformatf("empty_res %0b, want %0b", empty_res, e.empty));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (valid && ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_store_full();
    test_random();
    while (estimate_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
